// File: rtl/amou_pkg.sv
package amou_pkg;

	localparam int unsigned DATA_W          = 64;
	localparam int unsigned ADDR_W          = 13;
	// word address bits: byte address without the byte-in-word offset
	localparam int unsigned WA_W            = ADDR_W - 3;
	localparam int unsigned PAIR_BYTES      = 16;
	localparam int unsigned STORE_WORDS_DEF = 1024;

	typedef enum logic [3:0] {
		OP_CAS      = 4'd0,
		OP_CAS_PAIR = 4'd1,
		OP_ADD      = 4'd2,
		OP_SUB      = 4'd3,
		OP_AND      = 4'd4,
		OP_OR       = 4'd5,
		OP_XOR      = 4'd6,
		OP_SWAP     = 4'd7,
		OP_FADD     = 4'd8,
		OP_FSUB     = 4'd9,
		OP_FAND     = 4'd10,
		OP_FOR      = 4'd11,
		OP_FXOR     = 4'd12,
		OP_FNEG     = 4'd13
	} opcode_t;

	typedef enum logic [1:0] {
		SZ_1B = 2'd0,
		SZ_2B = 2'd1,
		SZ_4B = 2'd2,
		SZ_8B = 2'd3
	} size_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_READ,
		ST_READ_HI,
		ST_EXEC,
		ST_WRITE_HI
	} state_t;

	// controller -> datapath
	typedef struct packed {
		logic clr_wr;   // clearing pass: zero one word
		logic in_load;  // capture request
		logic rd_lo;    // read low (or only) word
		logic rd_hi;    // read high word of a 128-bit pair
		logic cap_lo;   // hold low word while high word is read
		logic wr_lo;    // write back low word
		logic wr_hi;    // write back high word of a pair
		logic out_load; // load response register
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic clr_last;
		logic bad;
		logic pair;
	} sts_t;

endpackage

// File: rtl/amou_req_if.sv
interface amou_req_if;
	import amou_pkg::*;

	logic                valid;
	logic                ready;
	logic [3:0]          opcode;
	logic [1:0]          size_code;
	logic [ADDR_W-1:0]   byte_address;
	logic [DATA_W-1:0]   operand_low;
	logic [DATA_W-1:0]   operand_high;
	logic [DATA_W-1:0]   expected_low;
	logic [DATA_W-1:0]   expected_high;

	modport source (
		output valid, opcode, size_code, byte_address,
		output operand_low, operand_high, expected_low, expected_high,
		input  ready
	);

	modport sink (
		input  valid, opcode, size_code, byte_address,
		input  operand_low, operand_high, expected_low, expected_high,
		output ready
	);

endinterface

// File: rtl/amou_rsp_if.sv
interface amou_rsp_if;
	import amou_pkg::*;

	logic              valid;
	logic              ready;
	logic [DATA_W-1:0] old_low;
	logic [DATA_W-1:0] old_high;
	logic              has_value;
	logic              bad_size;

	modport source (
		output valid, old_low, old_high, has_value, bad_size,
		input  ready
	);

	modport sink (
		input  valid, old_low, old_high, has_value, bad_size,
		output ready
	);

endinterface

// File: rtl/amou_ram.sv
module amou_ram #(
	parameter int unsigned WIDTH = 64,
	parameter int unsigned DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// File: rtl/amou_ctrl.sv
module amou_ctrl
	import amou_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_ready,
	input  logic rsp_ready,
	output logic rsp_valid,
	input  sts_t sts,
	output cmd_t cmd
);

	state_t state_q, state_d;
	logic   rsp_valid_q;
	logic   out_free;

	assign out_free  = !rsp_valid_q || rsp_ready;
	assign rsp_valid = rsp_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_d   = state_q;
		cmd       = '0;
		req_ready = 1'b0;
		case (state_q)
			ST_CLEAR: begin
				cmd.clr_wr = 1'b1;
				if (sts.clr_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					cmd.in_load = 1'b1;
					state_d     = ST_READ;
				end
			end
			ST_READ: begin
				// refused requests skip the memory
				if (sts.bad) begin
					state_d = ST_EXEC;
				end else begin
					cmd.rd_lo = 1'b1;
					state_d   = sts.pair ? ST_READ_HI : ST_EXEC;
				end
			end
			ST_READ_HI: begin
				cmd.rd_hi  = 1'b1;
				cmd.cap_lo = 1'b1;
				state_d    = ST_EXEC;
			end
			ST_EXEC: begin
				if (out_free) begin
					cmd.out_load = 1'b1;
					cmd.wr_lo    = !sts.bad;
					state_d      = sts.pair ? ST_WRITE_HI : ST_IDLE;
				end
			end
			ST_WRITE_HI: begin
				cmd.wr_hi = 1'b1;
				state_d   = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

// File: rtl/amou_dp.sv
module amou_dp
	import amou_pkg::*;
#(
	parameter int unsigned STORE_WORDS = STORE_WORDS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  cmd_t                cmd,
	output sts_t                sts,
	input  logic [3:0]          opcode,
	input  logic [1:0]          size_code,
	input  logic [ADDR_W-1:0]   byte_address,
	input  logic [DATA_W-1:0]   operand_low,
	input  logic [DATA_W-1:0]   operand_high,
	input  logic [DATA_W-1:0]   expected_low,
	input  logic [DATA_W-1:0]   expected_high,
	output logic [DATA_W-1:0]   old_low,
	output logic [DATA_W-1:0]   old_high,
	output logic                has_value,
	output logic                bad_size
);

	localparam int unsigned IDX_W = (STORE_WORDS > 1) ? $clog2(STORE_WORDS) : 1;
	localparam int unsigned CMP_W = (IDX_W + 1 > WA_W) ? IDX_W + 1 : WA_W;
	localparam int unsigned PRD_W = 2 * WA_W;
	localparam int unsigned QC_W  = WA_W + CMP_W;
	localparam int unsigned PAIR_SH = $clog2(PAIR_BYTES);
	// floor(2^WA_W / STORE_WORDS): quotient estimate is exact or one low
	localparam logic [WA_W-1:0]  RECIP = WA_W'((2 ** WA_W) / STORE_WORDS);
	localparam logic [CMP_W-1:0] C_CMP = CMP_W'(STORE_WORDS);
	localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(STORE_WORDS - 1);

	// request registers
	logic [3:0]        opcode_q;
	logic [1:0]        size_q;
	logic [ADDR_W-1:0] addr_q;
	logic [DATA_W-1:0] opl_q, oph_q, exl_q, exh_q;
	logic [WA_W-1:0]   wa_q;
	logic [PRD_W-1:0]  prod_q;
	logic [DATA_W-1:0] lo_word_q;
	logic              ok_q;
	logic [IDX_W-1:0]  clr_cnt_q;

	// response registers
	logic [DATA_W-1:0] old_low_q, old_high_q;
	logic              has_q, bad_q;

	logic              pair_in;
	logic [WA_W-1:0]   wa_in;
	logic [PRD_W-1:0]  prod_in;

	opcode_t           op;
	logic              pair128, bad, has;
	logic [WA_W-1:0]   quot;
	logic [QC_W-1:0]   qc;
	logic [WA_W-1:0]   rem0;
	logic [CMP_W-1:0]  rem_ext, rem_red;
	logic [IDX_W-1:0]  idx_lo, idx_hi;

	logic [DATA_W-1:0] rdata, word_lo, word_hi;
	logic [1:0]        eff_sz;
	logic [DATA_W-1:0] mask, old, v, exm, nv, nv_m, new_word, wdata_lo;
	logic [2:0]        off;
	logic [5:0]        sh;
	logic              ok;

	logic                ram_we, ram_re;
	logic [IDX_W-1:0]    ram_waddr, ram_raddr;
	logic [DATA_W-1:0]   ram_wdata;

	// word address at accept; product registered before the reduction
	assign pair_in = (opcode == OP_CAS_PAIR) && (size_code == SZ_8B);
	assign wa_in   = pair_in ? {byte_address[ADDR_W-1:PAIR_SH], 1'b0}
	                         : byte_address[ADDR_W-1:3];
	assign prod_in = PRD_W'(wa_in) * PRD_W'(RECIP);

	always_ff @(posedge clk) begin
		if (cmd.in_load) begin
			opcode_q <= opcode;
			size_q   <= size_code;
			addr_q   <= byte_address;
			opl_q    <= operand_low;
			oph_q    <= operand_high;
			exl_q    <= expected_low;
			exh_q    <= expected_high;
			wa_q     <= wa_in;
			prod_q   <= prod_in;
		end
		if (cmd.cap_lo) begin
			lo_word_q <= rdata;
		end
		if (cmd.out_load) begin
			ok_q       <= ok;
			old_low_q  <= has ? (pair128 ? word_lo : old) : '0;
			old_high_q <= (has && pair128) ? word_hi : '0;
			has_q      <= has;
			bad_q      <= bad;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_cnt_q <= '0;
		end else if (cmd.clr_wr) begin
			clr_cnt_q <= clr_cnt_q + 1'b1;
		end
	end

	// decode
	assign op      = opcode_t'(opcode_q);
	assign pair128 = (op == OP_CAS_PAIR) && (size_q == SZ_8B);
	assign bad     = ((op == OP_CAS_PAIR) && (size_q inside {SZ_1B, SZ_2B}))
	               || (opcode_q > OP_FNEG);
	assign has     = !bad && (op inside {OP_CAS, OP_CAS_PAIR, OP_SWAP,
	                                      [OP_FADD:OP_FNEG]});

	assign sts.clr_last = (clr_cnt_q == IDX_LAST);
	assign sts.bad      = bad;
	assign sts.pair     = pair128;

	// word index modulo STORE_WORDS: reciprocal estimate, one correction
	assign quot    = prod_q[PRD_W-1:WA_W];
	assign qc      = QC_W'(quot) * QC_W'(C_CMP);
	assign rem0    = wa_q - qc[WA_W-1:0];
	assign rem_ext = CMP_W'(rem0);
	assign rem_red = (rem_ext >= C_CMP) ? rem_ext - C_CMP : rem_ext;
	assign idx_lo  = rem_red[IDX_W-1:0];
	assign idx_hi  = (idx_lo == IDX_LAST) ? '0 : idx_lo + 1'b1;

	// lane operation
	assign word_lo = pair128 ? lo_word_q : rdata;
	assign word_hi = rdata;
	// 64-bit cas pair behaves as an 8-byte cas
	assign eff_sz  = (op == OP_CAS_PAIR) ? SZ_8B : size_q;

	always_comb begin
		case (size_t'(eff_sz))
			SZ_1B: begin
				mask = DATA_W'(8'hFF);
				off  = addr_q[2:0];
			end
			SZ_2B: begin
				mask = DATA_W'(16'hFFFF);
				off  = {addr_q[2:1], 1'b0};
			end
			SZ_4B: begin
				mask = DATA_W'(32'hFFFF_FFFF);
				off  = {addr_q[2], 2'b00};
			end
			default: begin
				mask = '1;
				off  = 3'b000;
			end
		endcase
	end

	assign sh  = {off, 3'b000};
	assign old = (word_lo >> sh) & mask;
	assign v   = opl_q & mask;
	assign exm = exl_q & mask;

	always_comb begin
		case (op)
			OP_CAS, OP_CAS_PAIR: nv = (old == exm) ? v : old;
			OP_ADD, OP_FADD:     nv = old + v;
			OP_SUB, OP_FSUB:     nv = old - v;
			OP_AND, OP_FAND:     nv = old & v;
			OP_OR,  OP_FOR:      nv = old | v;
			OP_XOR, OP_FXOR:     nv = old ^ v;
			OP_SWAP:             nv = v;
			default:             nv = '0 - old;
		endcase
	end

	assign nv_m     = nv & mask;
	assign new_word = (word_lo & ~(mask << sh)) | (nv_m << sh);
	assign ok       = (word_lo == exl_q) && (word_hi == exh_q);
	assign wdata_lo = pair128 ? (ok ? opl_q : word_lo) : new_word;

	// memory ports
	assign ram_re    = cmd.rd_lo | cmd.rd_hi;
	assign ram_raddr = cmd.rd_hi ? idx_hi : idx_lo;
	assign ram_we    = cmd.clr_wr | cmd.wr_lo | (cmd.wr_hi & ok_q);
	assign ram_waddr = cmd.clr_wr ? clr_cnt_q : (cmd.wr_hi ? idx_hi : idx_lo);
	assign ram_wdata = cmd.clr_wr ? '0 : (cmd.wr_hi ? oph_q : wdata_lo);

	amou_ram #(
		.WIDTH (DATA_W),
		.DEPTH (STORE_WORDS)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (rdata)
	);

	assign old_low   = old_low_q;
	assign old_high  = old_high_q;
	assign has_value = has_q;
	assign bad_size  = bad_q;

endmodule

// File: rtl/atomic_memory_op_unit.sv
// Channel | Dir | Carries
// --------+-----+----------------------------------------------------------
// req     | in  | opcode, size_code, byte_address, operand/expected lo+hi
// rsp     | out | old_low, old_high, has_value, bad_size
//
// Sequence: each transaction reads its word(s) from the store, then
//   writes back.
// Reset: arst_n clears control; a clearing pass then zeroes all
//   STORE_WORDS words of the store, with req.ready low.
// Stalls: the response register frees the request side; a new request is
//   taken while a response still waits, execution waits only if it is full.
module atomic_memory_op_unit
	import amou_pkg::*;
#(
	parameter int unsigned STORE_WORDS = STORE_WORDS_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	amou_req_if.sink  req,
	amou_rsp_if.source rsp
);

	cmd_t cmd;
	sts_t sts;

	// Sequencer: clearing pass, accept, read, high read, execute/write, high write.
	amou_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.rsp_ready (rsp.ready),
		.rsp_valid (rsp.valid),
		.sts       (sts),
		.cmd       (cmd)
	);

	// Request registers, index reduction, lane ALU, word store, response.
	amou_dp #(
		.STORE_WORDS (STORE_WORDS)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.sts           (sts),
		.opcode        (req.opcode),
		.size_code     (req.size_code),
		.byte_address  (req.byte_address),
		.operand_low   (req.operand_low),
		.operand_high  (req.operand_high),
		.expected_low  (req.expected_low),
		.expected_high (req.expected_high),
		.old_low       (rsp.old_low),
		.old_high      (rsp.old_high),
		.has_value     (rsp.has_value),
		.bad_size      (rsp.bad_size)
	);

endmodule

// File: rtl/amou_checker.sv
module amou_checker
	import amou_pkg::*;
(
	input logic              clk,
	input logic              arst_n,
	input logic              req_valid,
	input logic              req_ready,
	input logic              rsp_valid,
	input logic              rsp_ready,
	input logic [DATA_W-1:0] rsp_old_low,
	input logic [DATA_W-1:0] rsp_old_high,
	input logic              rsp_has_value,
	input logic              rsp_bad_size
);

	// one transaction in flight: no accept on the following cycle
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && req_ready) |=> !req_ready)
		else $error("request accepted back to back");

	a_bad_no_value: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> !(rsp_has_value && rsp_bad_size))
		else $error("refused transaction reports a value");

	a_no_value_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && !rsp_has_value) |-> (rsp_old_low == '0 && rsp_old_high == '0))
		else $error("valueless response carries data");

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && !rsp_ready) |=> rsp_valid)
		else $error("response dropped while stalled");

endmodule

bind atomic_memory_op_unit amou_checker u_amou_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.req_valid     (req.valid),
	.req_ready     (req.ready),
	.rsp_valid     (rsp.valid),
	.rsp_ready     (rsp.ready),
	.rsp_old_low   (rsp.old_low),
	.rsp_old_high  (rsp.old_high),
	.rsp_has_value (rsp.has_value),
	.rsp_bad_size  (rsp.bad_size)
);
